/* rtl/core/r2fft_pkg.sv */
`default_nettype none
package r2fft_pkg;
   localparam int MAX_LOG2_POINTS_DEF = 6;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int TWIDDLE_BITS_DEF = 18;
   localparam int TABLE_LOG2 = 6;

   typedef enum logic [2:0] {
      ST_LOAD, ST_RD, ST_WAIT, ST_MUL, ST_WR, ST_WR2, ST_OUT_RD, ST_OUT
   } state_type;

   typedef struct packed {
      logic load_we;
      logic bf_rd;
      logic bf_cap;
      logic bf_mul;
      logic bf_wr;
      logic out_rd;
      logic out_show;
   } cmd_type;

   function automatic logic signed [16:0] quarter_q16(input logic [4:0] k);
      logic signed [16:0] r;
      r = '0;
      case (k)
         5'd0: r = 17'sd65535; // 65536 held as 1.0 minus one; fixed below
         5'd1: r = 17'sd65220;
         5'd2: r = 17'sd64277;
         5'd3: r = 17'sd62714;
         5'd4: r = 17'sd60547;
         5'd5: r = 17'sd57798;
         5'd6: r = 17'sd54491;
         5'd7: r = 17'sd50660;
         5'd8: r = 17'sd46341;
         5'd9: r = 17'sd41576;
         5'd10: r = 17'sd36410;
         5'd11: r = 17'sd30893;
         5'd12: r = 17'sd25080;
         5'd13: r = 17'sd19024;
         5'd14: r = 17'sd12785;
         5'd15: r = 17'sd6424;
         default: r = 17'sd0;
      endcase
      return r;
   endfunction

   // Q16 value of cos table entry, 18 bits wide so 65536 fits
   function automatic logic signed [17:0] q16_val(input logic [4:0] k);
      logic signed [17:0] r;
      r = (k == 5'd0) ? 18'sd65536 : 18'(quarter_q16(k));
      return r;
   endfunction

   function automatic logic signed [47:0] scale_tw(input logic signed [17:0] q,
                                                    input int frac);
      logic signed [47:0] v;
      v = 48'(q);
      if (frac >= 16) v = v <<< (frac - 16);
      else v = (v + (48'sd1 <<< (15 - frac))) >>> (16 - frac);
      return v;
   endfunction
endpackage
`default_nettype wire

/* rtl/core/r2fft_ram.sv */
`default_nettype none
module r2fft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

/* rtl/core/r2fft_ctrl.sv */
`default_nettype none
module r2fft_ctrl import r2fft_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic load_done,
   input  wire logic bf_done,
   input  wire logic out_done,
   input  wire logic in_fire,
   input  wire logic out_fire,
   output cmd_type   cmd,
   output logic      in_ready
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: if (in_fire && load_done) state_in = ST_RD;
         ST_RD: state_in = ST_WAIT;
         ST_WAIT: state_in = ST_MUL;
         ST_MUL: state_in = ST_WR;
         ST_WR: state_in = ST_WR2;
         ST_WR2: state_in = bf_done ? ST_OUT_RD : ST_RD;
         ST_OUT_RD: state_in = ST_OUT;
         ST_OUT: if (out_fire) state_in = out_done ? ST_LOAD : ST_OUT_RD;
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd = '0;
      in_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            in_ready = 1'b1;
            cmd.load_we = in_fire;
         end
         ST_RD: cmd.bf_rd = 1'b1;
         ST_WAIT: cmd.bf_cap = 1'b1;
         ST_MUL: cmd.bf_mul = 1'b1;
         ST_WR: cmd.bf_wr = 1'b1;
         ST_WR2: cmd.bf_wr = 1'b1;
         ST_OUT_RD: cmd.out_rd = 1'b1;
         ST_OUT: cmd.out_show = 1'b1;
         default: cmd = '0;
      endcase
   end
endmodule
`default_nettype wire

/* rtl/core/r2fft_dp.sv */
`default_nettype none
module r2fft_dp import r2fft_pkg::*; #(
   parameter int MAX_LOG2_POINTS = MAX_LOG2_POINTS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF,
   localparam int BB = SAMPLE_BITS + MAX_LOG2_POINTS,
   localparam int AW = MAX_LOG2_POINTS,
   localparam int LW = $clog2(MAX_LOG2_POINTS + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  cmd_type                            cmd,
   input  wire logic                          cfg_we,
   input  wire logic [2:0]                    cfg_data,
   input  wire logic signed [SAMPLE_BITS-1:0] in_re,
   input  wire logic signed [SAMPLE_BITS-1:0] in_im,
   input  wire logic                          out_fire,
   output logic                               load_done,
   output logic                               bf_done,
   output logic                               out_done,
   output logic signed [BB-1:0]               out_re,
   output logic signed [BB-1:0]               out_im,
   output logic [AW-1:0]                      out_idx,
   output logic                               out_last
);
   localparam int TF = TWIDDLE_BITS - 2;
   localparam int PW = BB + TWIDDLE_BITS + 1;
   localparam int MW = BB + TWIDDLE_BITS;

   logic [2:0] lg_ff;
   logic [AW:0] cnt_ff;
   logic [LW-1:0] stage_ff;
   logic [AW-1:0] j_ff;
   logic [AW-1:0] grp_ff;
   logic phase_ff;
   logic [LW-1:0] elg;
   logic [AW:0] npts;

   always_comb begin
      elg = (lg_ff == 3'd0) ? LW'(1) :
            (32'(lg_ff) > MAX_LOG2_POINTS) ? LW'(MAX_LOG2_POINTS) : LW'(lg_ff);
      npts = (AW+1)'(1) << elg;
   end

   // bit reverse of load count
   logic [AW-1:0] rev;
   always_comb begin
      rev = '0;
      for (int b = 0; b < AW; b++)
         if (b < 32'(elg)) rev[32'(elg) - 1 - b] = cnt_ff[b];
   end

   // butterfly addresses
   logic [LW-1:0] half_sh;
   logic [AW-1:0] half, p_addr, q_addr, tw_k;
   always_comb begin
      half_sh = stage_ff - LW'(1);
      half = AW'(1) << half_sh;
      p_addr = (grp_ff << stage_ff) + j_ff;
      q_addr = p_addr + half;
      tw_k = AW'(32'(j_ff) << (TABLE_LOG2 - 32'(stage_ff)));
   end

   // memory port
   logic we;
   logic [AW-1:0] waddr, raddr;
   logic [2*BB-1:0] wdata, rdata;

   logic signed [BB-1:0] ur_ff, ui_ff, br_ff, bi_ff;
   logic signed [PW-1:0] vr_ff, vi_ff;
   logic signed [TWIDDLE_BITS-1:0] c_ff, s_ff;
   logic signed [MW-1:0] p_rc, p_is, p_ic, p_rs;

   function automatic logic signed [BB-1:0] sat(input logic signed [BB+1:0] x);
      logic signed [BB+1:0] hi, lo;
      hi = (BB+2)'((48'sd1 <<< (BB-1)) - 1);
      lo = -hi - 1;
      return (x > hi) ? BB'(hi) : (x < lo) ? BB'(lo) : BB'(x);
   endfunction

   // rounded products can exceed the bin range, so keep one extra bit
   logic signed [BB:0] vr_r, vi_r;
   always_comb begin
      vr_r = (BB+1)'((vr_ff + (PW'(1) <<< (TF-1))) >>> TF);
      vi_r = (BB+1)'((vi_ff + (PW'(1) <<< (TF-1))) >>> TF);
   end

   always_comb begin
      we = 1'b0;
      waddr = rev;
      wdata = {BB'(in_im), BB'(in_re)};
      raddr = phase_ff ? q_addr : p_addr;
      if (cmd.load_we) we = 1'b1;
      else if (cmd.bf_wr) begin
         we = 1'b1;
         waddr = phase_ff ? q_addr : p_addr;
         wdata = phase_ff ?
            {sat((BB+2)'(ui_ff) - (BB+2)'(vi_r)), sat((BB+2)'(ur_ff) - (BB+2)'(vr_r))} :
            {sat((BB+2)'(ui_ff) + (BB+2)'(vi_r)), sat((BB+2)'(ur_ff) + (BB+2)'(vr_r))};
      end
      if (cmd.out_rd || cmd.out_show) raddr = cnt_ff[AW-1:0];
   end

   r2fft_ram #(.WIDTH(2*BB), .DEPTH(1 << AW)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   // twiddle lookup
   logic signed [47:0] cw, sw;
   logic [4:0] km;
   always_comb begin
      km = 5'(tw_k);
      cw = (km <= 5'd16) ? scale_tw(q16_val(km), TF) : -scale_tw(q16_val(5'(6'd32 - 6'(km))), TF);
      sw = (km <= 5'd16) ? scale_tw(q16_val(5'(5'd16 - km)), TF) :
                           scale_tw(q16_val(5'(km - 5'd16)), TF);
   end

   // load/output counters and butterfly flow: read q, read p, multiply, write p, write q
   always_ff @(posedge clock) begin
      if (reset) begin
         lg_ff <= 3'd6;
         cnt_ff <= '0;
         stage_ff <= LW'(1);
         j_ff <= '0;
         grp_ff <= '0;
         phase_ff <= 1'b1;
      end else begin
         if (cfg_we) lg_ff <= cfg_data;
         if (cmd.load_we) begin
            if (load_done) begin
               cnt_ff <= '0;
               stage_ff <= LW'(1);
               j_ff <= '0;
               grp_ff <= '0;
               phase_ff <= 1'b1;
            end else cnt_ff <= cnt_ff + 1'b1;
         end else if (cfg_we) cnt_ff <= '0;
         else if (out_fire) cnt_ff <= out_done ? '0 : cnt_ff + 1'b1;
         if (cmd.bf_rd) phase_ff <= 1'b0;
         if (cmd.bf_mul) phase_ff <= 1'b0;
         if (cmd.bf_wr) begin
            if (!phase_ff) phase_ff <= 1'b1;
            else if (32'(j_ff) + 1 < 32'(half)) j_ff <= j_ff + 1'b1;
            else begin
               j_ff <= '0;
               if ((32'(grp_ff) + 1) << stage_ff < 32'(npts)) grp_ff <= grp_ff + 1'b1;
               else begin
                  grp_ff <= '0;
                  stage_ff <= stage_ff + 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      p_rc = br_ff * c_ff;
      p_is = bi_ff * s_ff;
      p_ic = bi_ff * c_ff;
      p_rs = br_ff * s_ff;
   end

   // RD issues the q read, WAIT captures q while p is read
   always_ff @(posedge clock) begin
      if (cmd.bf_rd) begin
         c_ff <= TWIDDLE_BITS'(cw);
         s_ff <= TWIDDLE_BITS'(sw);
      end
      if (cmd.bf_cap) begin
         br_ff <= rdata[BB-1:0];
         bi_ff <= rdata[2*BB-1:BB];
      end
      if (cmd.bf_mul) begin
         ur_ff <= rdata[BB-1:0];
         ui_ff <= rdata[2*BB-1:BB];
         vr_ff <= PW'(p_rc) + PW'(p_is);
         vi_ff <= PW'(p_ic) - PW'(p_rs);
      end
   end

   always_comb begin
      load_done = (cnt_ff + 1'b1) >= npts;
      bf_done = (stage_ff == elg) && (32'(j_ff) + 1 >= 32'(half)) &&
                (((32'(grp_ff) + 1) << stage_ff) >= 32'(npts)) && phase_ff;
      out_done = (cnt_ff + 1'b1) >= npts;
      out_re = rdata[BB-1:0];
      out_im = rdata[2*BB-1:BB];
      out_idx = cnt_ff[AW-1:0];
      out_last = out_done;
   end
endmodule
`default_nettype wire

/* rtl/core/radix2_fft_core.sv */
// Load: one sample per cycle while req_tvalid is high, 2^log2_size samples (0 as 1, clamped to MAX_LOG2_POINTS).
// Compute: each butterfly steps RD, WAIT, MUL, WR, WR2 (one RAM read port), N/2*log2N butterflies.
// The first bin is read in ST_OUT_RD once the last butterfly is written.
// Output: each bin steps ST_OUT_RD then ST_OUT on the RAM read port, plus any stall.
// Synchronous active-high reset; log2_size resets to 6, sample count to 0.
`default_nettype none
module radix2_fft_core import r2fft_pkg::*; #(
   parameter int MAX_LOG2_POINTS = MAX_LOG2_POINTS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF,
   localparam int BB = SAMPLE_BITS + MAX_LOG2_POINTS,
   localparam int OW = ((2*BB+MAX_LOG2_POINTS+7)/8)*8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [2:0]                 csr_data,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [2*SAMPLE_BITS-1:0]   req_tdata,  // sample_re, sample_im
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [OW-1:0]                   rsp_tdata, // bin_re, bin_im, bin_index
   output logic                            rsp_tlast   // last_bin
);
   cmd_type cmd;
   logic load_done, bf_done, out_done, in_fire, out_fire, out_last;
   logic signed [BB-1:0] out_re, out_im;
   logic [MAX_LOG2_POINTS-1:0] out_idx;

   assign in_fire = req_tvalid && req_tready;
   assign out_fire = rsp_tvalid && rsp_tready;
   assign csr_ready = req_tready;

   r2fft_ctrl u_ctrl (
      .clock(clock), .reset(reset), .load_done(load_done), .bf_done(bf_done),
      .out_done(out_done), .in_fire(in_fire), .out_fire(out_fire),
      .cmd(cmd), .in_ready(req_tready)
   );

   r2fft_dp #(.MAX_LOG2_POINTS(MAX_LOG2_POINTS), .SAMPLE_BITS(SAMPLE_BITS),
              .TWIDDLE_BITS(TWIDDLE_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .cfg_we(csr_valid && csr_ready),
      .cfg_data(csr_data),
      .in_re(req_tdata[SAMPLE_BITS-1:0]), .in_im(req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .out_fire(out_fire), .load_done(load_done), .bf_done(bf_done), .out_done(out_done),
      .out_re(out_re), .out_im(out_im), .out_idx(out_idx), .out_last(out_last)
   );

   assign rsp_tvalid = cmd.out_show;
   assign rsp_tlast = out_last;
   assign rsp_tdata = OW'({out_idx, out_im, out_re});

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("load during output");
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      (out_fire && rsp_tlast) |=> req_tready) else $error("no reload after last");
`endif
endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
   localparam int NPTS_MAX = 64;
   localparam int OUT_W = 56;
   localparam int SETTLE = 60;

   typedef enum int {ACT_SAMPLE, ACT_CSR, ACT_DRAIN, ACT_MODE} act_kind_type;
   typedef struct {
      act_kind_type kind;
      logic [31:0]  data;
      int           send_idle;
      int           recv_stall;
   } action_type;
   typedef struct {
      logic [21:0] re;
      logic [21:0] im;
      logic [5:0]  index;
      logic        last;
   } bin_type;

   localparam int COS_Q16 [17] = '{65536, 65220, 64277, 62714, 60547, 57798, 54491, 50660,
      46341, 41576, 36410, 30893, 25080, 19024, 12785, 6424, 0};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;
   logic rsp_tlast;

   action_type pending[$];
   bin_type expected_bins[$];
   longint fft_re[NPTS_MAX];
   longint fft_im[NPTS_MAX];
   int size_reg = 6;
   int load_cnt = 0;
   int errors = 0;
   int send_idle = 0;
   int recv_stall = 0;
   int hold = 0;
   bit req_busy = 0;
   bit csr_busy = 0;
   bit req_fire = 0;
   bit csr_fire = 0;

   radix2_fft_core DUT (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint sat22(longint x);
      if (x > 2097151) return 2097151;
      if (x < -2097152) return -2097152;
      return x;
   endfunction

   function automatic longint tw_cos(int k);
      return (k <= 16) ? COS_Q16[k] : -COS_Q16[32-k];
   endfunction

   function automatic longint tw_sin(int k);
      return (k <= 16) ? COS_Q16[16-k] : COS_Q16[k-16];
   endfunction

   task automatic predict_sample(logic [31:0] d);
      int lg, n, pos, half, k, p, q;
      longint c, sn, br, bi, vr, vi, ur, ui;
      bin_type b;
      lg = (size_reg < 1) ? 1 : ((size_reg > 6) ? 6 : size_reg);
      n = 1 << lg;
      if (load_cnt >= n) load_cnt = 0;
      pos = 0;
      for (int i = 0; i < lg; i++) pos |= ((load_cnt >> i) & 1) << (lg - 1 - i);
      fft_re[pos] = longint'($signed(d[15:0]));
      fft_im[pos] = longint'($signed(d[31:16]));
      load_cnt++;
      if (load_cnt < n) return;
      load_cnt = 0;
      for (int s = 1; s <= lg; s++) begin
         half = 1 << (s - 1);
         for (int i = 0; i < n; i += 2 * half) begin
            for (int j = 0; j < half; j++) begin
               k = j << (6 - s);
               p = i + j;
               q = i + j + half;
               c = tw_cos(k);
               sn = tw_sin(k);
               br = fft_re[q];
               bi = fft_im[q];
               vr = (br * c + bi * sn + 32768) >>> 16;
               vi = (bi * c - br * sn + 32768) >>> 16;
               ur = fft_re[p];
               ui = fft_im[p];
               fft_re[p] = sat22(ur + vr);
               fft_im[p] = sat22(ui + vi);
               fft_re[q] = sat22(ur - vr);
               fft_im[q] = sat22(ui - vi);
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         b.re = fft_re[i][21:0];
         b.im = fft_im[i][21:0];
         b.index = i[5:0];
         b.last = (i == n - 1);
         expected_bins.push_back(b);
      end
   endtask

   function automatic logic [15:0] rand_half();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_item(act_kind_type kind, logic [31:0] d, int si = 0, int rs = 0);
      action_type a;
      a.kind = kind;
      a.data = d;
      a.send_idle = si;
      a.recv_stall = rs;
      pending.push_back(a);
   endtask

   task automatic set_size(int lg);
      add_item(ACT_DRAIN, '0);
      add_item(ACT_CSR, 32'(lg));
   endtask

   task automatic add_frame(int len);
      for (int i = 0; i < len; i++) add_item(ACT_SAMPLE, {rand_half(), rand_half()});
   endtask

   // posedge: sample handshakes, check bins
   always @(posedge clock) begin
      bin_type e;
      req_fire = req_tvalid && req_tready && !reset;
      csr_fire = csr_valid && csr_ready && !reset;
      if (csr_fire) begin
         size_reg = csr_data;
         load_cnt = 0;
      end
      if (req_fire) predict_sample(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bins.size() == 0) begin
            $error("unexpected bin: tdata=%h", rsp_tdata);
            errors++;
         end else begin
            e = expected_bins.pop_front();
            if (rsp_tdata[21:0] !== e.re) begin
               $error("bin_re: expected %h, got %h", e.re, rsp_tdata[21:0]);
               errors++;
            end
            if (rsp_tdata[43:22] !== e.im) begin
               $error("bin_im: expected %h, got %h", e.im, rsp_tdata[43:22]);
               errors++;
            end
            if (rsp_tdata[49:44] !== e.index) begin
               $error("bin_index: expected %0d, got %0d", e.index, rsp_tdata[49:44]);
               errors++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last_bin: expected %b, got %b", e.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // negedge: drive stimulus from the pending queue
   always @(negedge clock) begin
      action_type a;
      if (!reset) begin
         if (req_fire) req_busy = 0;
         if (csr_fire) csr_busy = 0;
         if (!req_busy && !csr_busy && pending.size() > 0) begin
            a = pending[0];
            if (hold > 0) begin
               hold--;
            end else begin
               case (a.kind)
                  ACT_SAMPLE: begin
                     if ($urandom_range(99) >= send_idle) begin
                        void'(pending.pop_front());
                        req_tdata <= a.data;
                        req_busy = 1;
                     end
                  end
                  ACT_CSR: begin
                     void'(pending.pop_front());
                     csr_data <= a.data[2:0];
                     csr_busy = 1;
                  end
                  ACT_DRAIN: begin
                     if (expected_bins.size() == 0) begin
                        void'(pending.pop_front());
                        hold = SETTLE;
                     end
                  end
                  ACT_MODE: begin
                     void'(pending.pop_front());
                     send_idle = a.send_idle;
                     recv_stall = a.recv_stall;
                  end
                  default: begin
                     void'(pending.pop_front());
                  end
               endcase
            end
         end
         req_tvalid <= req_busy;
         csr_valid <= csr_busy;
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   initial begin
      int lg, n, count, phase, nf, plen;
      int sizes[$];
      // directed: extremes at two points
      set_size(1);
      add_item(ACT_SAMPLE, 32'h7fff_7fff);
      add_item(ACT_SAMPLE, 32'h8000_8000);
      add_item(ACT_SAMPLE, 32'h7fff_8000);
      add_item(ACT_SAMPLE, 32'h8000_7fff);
      // size zero acts as two points
      set_size(0);
      add_item(ACT_SAMPLE, 32'h0000_0001);
      add_item(ACT_SAMPLE, 32'hffff_0000);
      // impulse at four points
      set_size(2);
      add_item(ACT_SAMPLE, 32'h0000_7fff);
      add_item(ACT_SAMPLE, 32'h0);
      add_item(ACT_SAMPLE, 32'h0);
      add_item(ACT_SAMPLE, 32'h0);
      // partial frame, then restart by register write
      add_item(ACT_SAMPLE, 32'h1234_5678);
      add_item(ACT_SAMPLE, 32'h8765_4321);
      set_size(3);
      for (int i = 0; i < 8; i++) add_item(ACT_SAMPLE, (i % 2) ? 32'h8000_8000 : 32'h7fff_7fff);
      // random
      sizes = '{1, 7, 2, 3, 0, 4, 2, 6, 1, 5, 3, 2};
      count = 20;
      phase = 0;
      while (count < 230) begin
         case (phase % 4)
            0: add_item(ACT_MODE, '0, 0, 0);
            1: add_item(ACT_MODE, '0, 58, 0);
            2: add_item(ACT_MODE, '0, 0, 58);
            default: add_item(ACT_MODE, '0, 28, 28);
         endcase
         lg = sizes[phase % sizes.size()];
         n = 1 << ((lg < 1) ? 1 : ((lg > 6) ? 6 : lg));
         set_size(lg);
         nf = (n >= 32) ? 1 : $urandom_range(4, 2);
         for (int f = 0; f < nf && count < 230; f++) begin
            add_frame(n);
            count += n;
            if ($urandom_range(3) == 0) add_item(ACT_DRAIN, '0);
         end
         if (count < 230 && $urandom_range(2) == 0) begin
            plen = $urandom_range(n - 1, 1);
            add_frame(plen);
            count += plen;
         end
         phase++;
      end
      add_item(ACT_MODE, '0, 0, 0);

      repeat (10) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      wait (pending.size() == 0 && !req_busy && !csr_busy && expected_bins.size() == 0);
      repeat (400) @(posedge clock);
      if (errors == 0 && expected_bins.size() == 0) begin
         $display("** radix2_fft_core: PASSED **");
      end else begin
         $display("** radix2_fft_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("** radix2_fft_core: FAILED **");
      $finish;
   end
endmodule
